@@ sv/gpfp_pkg.sv @@
// Package for the GNSS position frame parser: frame constants, status codes
// and field widths. No dependencies.
`default_nettype none

package gpfp_pkg;

    localparam logic [7:0] SyncFirst  = 8'hB5;
    localparam logic [7:0] SyncSecond = 8'h62;
    localparam logic [7:0] FrameClass = 8'h01;
    localparam logic [7:0] FrameId    = 8'h02;
    localparam logic [7:0] FrameLen   = 8'd28;

    localparam int PayloadBytes = 28;
    localparam int PayloadWords = PayloadBytes / 4;
    localparam int IndexWidth   = $clog2(PayloadBytes);
    localparam int DataWidth    = PayloadBytes * 8;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_HEADER   = 2'd1,
        STATUS_CHECKSUM = 2'd2
    } status_t;

endpackage

`default_nettype wire

@@ sv/gnss_position_frame_parser.sv @@
// Byte-serial parser for a 28-byte position frame with two-byte Fletcher sum.
// Depends on gpfp_pkg.
// An accepted byte is held in in_byte_reg; a result it causes is then registered at the output.
// Throughput: one byte per cycle; s_tready falls only while a held result
// and a held input byte both wait on m_tready.
// Reset: aresetn synchronous, active low; clears parser state and both valids.
`default_nettype none

module gnss_position_frame_parser
    import gpfp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,  // rx_byte
    input  wire logic                 s_tuser,  // frame_start
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // time_of_week_ms, longitude, latitude, ellipsoid_height,
    // sea_level_height, horiz_accuracy, vert_accuracy (32 bits each)
    output logic [DataWidth-1:0]      m_tdata,
    output logic [1:0]                m_tuser   // status
);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LENLO   = 4'd4,
        PH_LENHI   = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CKA     = 4'd7,
        PH_CKB     = 4'd8
    } phase_t;

    logic                           in_valid_reg;
    logic [7:0]                     in_byte_reg;
    logic                           in_start_reg;

    phase_t                         phase_reg, phase_next;
    logic [IndexWidth-1:0]          index_reg, index_next;
    logic [7:0]                     sum_a_reg, sum_a_next;
    logic [7:0]                     sum_b_reg, sum_b_next;
    logic [7:0]                     len_low_reg, len_low_next;
    logic [7:0]                     exp_a_reg, exp_a_next;
    logic [PayloadBytes-1:0][7:0]   payload_reg;

    logic                           m_valid_reg;
    logic [DataWidth-1:0]           m_data_reg;
    status_t                        m_status_reg;

    logic                           process;
    logic                           emit;
    logic                           capture;
    status_t                        status_next;
    logic [7:0]                     b;
    logic [7:0]                     sum_a_add;

    assign process  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || process;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;
    assign b        = in_byte_reg;
    assign sum_a_add = sum_a_reg + b;

    always_comb begin
        phase_next   = phase_reg;
        index_next   = index_reg;
        sum_a_next   = sum_a_reg;
        sum_b_next   = sum_b_reg;
        len_low_next = len_low_reg;
        exp_a_next   = exp_a_reg;
        emit         = 1'b0;
        capture      = 1'b0;
        status_next  = STATUS_HEADER;

        if (in_start_reg) begin
            index_next = '0;
            if (b == SyncFirst) begin
                phase_next = PH_SYNC2;
            end else if (b != FrameClass) begin
                emit       = 1'b1;
                phase_next = PH_IDLE;
            end else begin
                sum_a_next = b;
                sum_b_next = b;
                phase_next = PH_ID;
            end
        end else begin
            unique case (phase_reg)
                PH_SYNC2: begin
                    if (b == SyncSecond) begin
                        phase_next = PH_CLASS;
                    end else begin
                        emit       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                PH_CLASS: begin
                    if (b != FrameClass) begin
                        emit       = 1'b1;
                        phase_next = PH_IDLE;
                    end else begin
                        sum_a_next = b;
                        sum_b_next = b;
                        phase_next = PH_ID;
                    end
                end
                PH_ID: begin
                    if (b != FrameId) begin
                        emit       = 1'b1;
                        phase_next = PH_IDLE;
                    end else begin
                        sum_a_next = sum_a_add;
                        sum_b_next = sum_b_reg + sum_a_add;
                        phase_next = PH_LENLO;
                    end
                end
                PH_LENLO: begin
                    len_low_next = b;
                    sum_a_next   = sum_a_add;
                    sum_b_next   = sum_b_reg + sum_a_add;
                    phase_next   = PH_LENHI;
                end
                PH_LENHI: begin
                    if (b != 8'h00 || len_low_reg != FrameLen) begin
                        emit       = 1'b1;
                        phase_next = PH_IDLE;
                    end else begin
                        sum_a_next = sum_a_add;
                        sum_b_next = sum_b_reg + sum_a_add;
                        index_next = '0;
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    capture    = 1'b1;
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_reg + sum_a_add;
                    index_next = index_reg + 1'b1;
                    if (index_reg == IndexWidth'(PayloadBytes - 1)) begin
                        phase_next = PH_CKA;
                    end
                end
                PH_CKA: begin
                    exp_a_next = b;
                    phase_next = PH_CKB;
                end
                PH_CKB: begin
                    emit        = 1'b1;
                    phase_next  = PH_IDLE;
                    status_next = (exp_a_reg == sum_a_reg && b == sum_b_reg)
                                  ? STATUS_OK : STATUS_CHECKSUM;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            phase_reg    <= PH_IDLE;
            index_reg    <= '0;
            sum_a_reg    <= '0;
            sum_b_reg    <= '0;
            len_low_reg  <= '0;
            exp_a_reg    <= '0;
            m_status_reg <= STATUS_OK;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (process && emit) begin
                m_valid_reg  <= 1'b1;
                m_status_reg <= status_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (process) begin
                phase_reg   <= phase_next;
                index_reg   <= index_next;
                sum_a_reg   <= sum_a_next;
                sum_b_reg   <= sum_b_next;
                len_low_reg <= len_low_next;
                exp_a_reg   <= exp_a_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (process && capture) begin
            payload_reg[index_reg] <= b;
        end
        if (process && emit) begin
            m_data_reg <= (status_next == STATUS_OK) ? DataWidth'(payload_reg)
                                                     : '0;
        end
    end

    property p_reject_zero_data;
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STATUS_OK |-> m_tdata == '0;
    endproperty
    a_reject_zero_data: assert property (p_reject_zero_data)
        else $error("non-ok result carries data");

    property p_status_code;
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STATUS_OK || m_tuser == STATUS_HEADER ||
                      m_tuser == STATUS_CHECKSUM);
    endproperty
    a_status_code: assert property (p_status_code)
        else $error("undefined status code");

    property p_stall_cause;
        @(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && m_valid_reg && !m_tready;
    endproperty
    a_stall_cause: assert property (p_stall_cause)
        else $error("input stalled without a blocked result");

    property p_index_range;
        @(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> index_reg < IndexWidth'(PayloadBytes);
    endproperty
    a_index_range: assert property (p_index_range)
        else $error("payload index out of range");

    property p_result_after_check;
        @(posedge aclk) disable iff (!aresetn)
        process && !in_start_reg && phase_reg == PH_CKB |=> m_valid_reg;
    endproperty
    a_result_after_check: assert property (p_result_after_check)
        else $error("no result after second check byte");

endmodule

`default_nettype wire

@@ bench/tb_gnss_position_frame_parser.sv @@
// Testbench for gnss_position_frame_parser: streams position frames byte by byte,
// predicts each status and field set, and checks results under random flow control.
// Depends on gpfp_pkg and the parser RTL.
module tb_gnss_position_frame_parser;
    import gpfp_pkg::*;

    typedef enum logic [3:0] {
        WAIT_START, WAIT_SYNC2, WAIT_CLASS, WAIT_ID, WAIT_LEN_LO, WAIT_LEN_HI,
        IN_PAYLOAD, WAIT_CK_A, WAIT_CK_B
    } parse_phase_t;

    typedef enum int {
        FAULT_NONE, FAULT_SYNC, FAULT_CLASS, FAULT_ID, FAULT_LEN_LO, FAULT_LEN_HI,
        FAULT_CK_A, FAULT_CK_B, FAULT_CUT
    } frame_fault_t;

    typedef struct packed {
        status_t                status;
        logic [DataWidth-1:0]   fields;
    } fix_t;

    class fix_scoreboard;
        parse_phase_t phase;
        logic [4:0]   pay_idx;
        logic [7:0]   run_a;
        logic [7:0]   run_b;
        logic [7:0]   len_low;
        logic [7:0]   check_a;
        logic [31:0]  words [PayloadWords];
        fix_t         pending_fixes [$];
        int           errors;

        function new();
            phase = WAIT_START;
            pay_idx = '0;
            run_a = '0;
            run_b = '0;
            len_low = '0;
            check_a = '0;
            foreach (words[k]) words[k] = '0;
            errors = 0;
        endfunction

        function void add_sum(logic [7:0] b);
            run_a = run_a + b;
            run_b = run_b + run_a;
        endfunction

        function void emit(status_t s);
            fix_t f;
            int   k;
            f.status = s;
            f.fields = '0;
            if (s == STATUS_OK) begin
                for (k = 0; k < PayloadWords; k++) f.fields[32*k +: 32] = words[k];
            end
            pending_fixes = {pending_fixes, f};
            phase = WAIT_START;
        endfunction

        function void take_class(logic [7:0] b);
            if (b != FrameClass) begin
                emit(STATUS_HEADER);
            end else begin
                run_a = '0;
                run_b = '0;
                add_sum(b);
                phase = WAIT_ID;
            end
        endfunction

        function void note_byte(logic [7:0] b, logic start);
            int w;
            if (start) begin
                pay_idx = '0;
                if (b == SyncFirst) phase = WAIT_SYNC2;
                else take_class(b);
            end else begin
                case (phase)
                    WAIT_SYNC2: begin
                        if (b == SyncSecond) phase = WAIT_CLASS;
                        else emit(STATUS_HEADER);
                    end
                    WAIT_CLASS: take_class(b);
                    WAIT_ID: begin
                        if (b != FrameId) begin
                            emit(STATUS_HEADER);
                        end else begin
                            add_sum(b);
                            phase = WAIT_LEN_LO;
                        end
                    end
                    WAIT_LEN_LO: begin
                        len_low = b;
                        add_sum(b);
                        phase = WAIT_LEN_HI;
                    end
                    WAIT_LEN_HI: begin
                        if (b != 8'd0 || len_low != FrameLen) begin
                            emit(STATUS_HEADER);
                        end else begin
                            add_sum(b);
                            pay_idx = '0;
                            phase = IN_PAYLOAD;
                        end
                    end
                    IN_PAYLOAD: begin
                        w = pay_idx >> 2;
                        if (pay_idx[1:0] == 2'd0) words[w] = {24'd0, b};
                        else words[w][8*pay_idx[1:0] +: 8] = b;
                        add_sum(b);
                        pay_idx = pay_idx + 5'd1;
                        if (pay_idx >= PayloadBytes) phase = WAIT_CK_A;
                    end
                    WAIT_CK_A: begin
                        check_a = b;
                        phase = WAIT_CK_B;
                    end
                    WAIT_CK_B: begin
                        if (check_a == run_a && b == run_b) emit(STATUS_OK);
                        else emit(STATUS_CHECKSUM);
                    end
                    default: phase = WAIT_START;
                endcase
            end
        endfunction

        function int pending();
            return pending_fixes.size();
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("mismatch: %s", msg);
        endfunction

        function void check_result(logic [1:0] status, logic [DataWidth-1:0] fields);
            fix_t  want;
            string names [PayloadWords];
            int    k;
            names = '{"time_of_week_ms", "longitude", "latitude", "ellipsoid_height",
                      "sea_level_height", "horiz_accuracy", "vert_accuracy"};
            if (pending_fixes.size() == 0) begin
                flag($sformatf("result with none expected, status %0d", status));
                return;
            end
            want = pending_fixes.pop_front();
            if (status !== want.status)
                flag($sformatf("status expected %0d got %0d", want.status, status));
            for (k = 0; k < PayloadWords; k++) begin
                if (fields[32*k +: 32] !== want.fields[32*k +: 32])
                    flag($sformatf("%s expected %h got %h", names[k],
                                   want.fields[32*k +: 32], fields[32*k +: 32]));
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;   // rx_byte
    logic                 s_tuser;   // frame_start
    logic                 m_tvalid;
    logic                 m_tready;
    logic [DataWidth-1:0] m_tdata;   // time_of_week_ms .. vert_accuracy, 32 bits each
    logic [1:0]           m_tuser;   // status

    fix_scoreboard sb;
    bit            no_idle;
    bit            hold_request;
    int            items_taken;

    gnss_position_frame_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("timeout waiting for results");
        $display("Some tests failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] other_than(logic [7:0] good);
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if (v == good) v = ~good;
        return v;
    endfunction

    function automatic void random_payload(output logic [31:0] w [PayloadWords]);
        int k;
        for (k = 0; k < PayloadWords; k++) begin
            case ($urandom_range(0, 9))
                0: w[k] = 32'h0000_0000;
                1: w[k] = 32'hFFFF_FFFF;
                2: w[k] = 32'h8000_0000;
                3: w[k] = 32'h7FFF_FFFF;
                default: w[k] = $urandom;
            endcase
        end
    endfunction

    task automatic send_byte(logic [7:0] b, logic start);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(b, start);
        items_taken++;
    endtask

    task automatic send_frame(input logic [31:0] w [PayloadWords], input bit with_sync,
                              input frame_fault_t fault);
        logic [7:0] bytes [$];
        logic [7:0] a;
        logic [7:0] b;
        int         first;
        int         n;
        int         k;
        if (with_sync) begin
            bytes = {bytes, SyncFirst};
            bytes = {bytes, (fault == FAULT_SYNC ? other_than(SyncSecond) : SyncSecond)};
        end
        first = bytes.size();
        bytes = {bytes, (fault == FAULT_CLASS  ? other_than(FrameClass) : FrameClass)};
        bytes = {bytes, (fault == FAULT_ID     ? other_than(FrameId)    : FrameId)};
        bytes = {bytes, (fault == FAULT_LEN_LO ? other_than(FrameLen)   : FrameLen)};
        bytes = {bytes, (fault == FAULT_LEN_HI ? other_than(8'd0)       : 8'd0)};
        for (k = 0; k < PayloadBytes; k++) bytes = {bytes, w[k/4][8*(k%4) +: 8]};
        a = '0;
        b = '0;
        for (k = first; k < bytes.size(); k++) begin
            a = a + bytes[k];
            b = b + a;
        end
        bytes = {bytes, (fault == FAULT_CK_A ? other_than(a) : a)};
        bytes = {bytes, (fault == FAULT_CK_B ? other_than(b) : b)};
        n = bytes.size();
        if (fault == FAULT_CUT) n = $urandom_range(1, n - 1);
        for (k = 0; k < n; k++) send_byte(bytes[k], k == 0);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic hold_ready(bit level, int cycles);
        @(negedge aclk);
        m_tready <= level;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    initial begin
        int n;
        bit held;
        m_tready = 1'b0;
        held = 1'b0;
        while (aresetn !== 1'b1) @(negedge aclk);
        forever begin
            if (hold_request && !held) begin
                held = 1'b1;
                @(negedge aclk);
                m_tready <= 1'b0;
                for (n = 0; n < 400; n++) @(negedge aclk);
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: hold_ready(1'b1, $urandom_range(1, 8));
                    4:          hold_ready(1'b1, $urandom_range(40, 150));
                    default:    hold_ready(1'b0, pick_gap() + 1);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    end

    initial begin
        logic [31:0]  pay [PayloadWords];
        frame_fault_t f;
        int           r;
        int           frames;
        sb = new();
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        aresetn = 1'b0;
        no_idle = 1'b0;
        hold_request = 1'b0;
        items_taken = 0;
        frames = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (pay[k]) pay[k] = 32'h0000_0000;
        send_frame(pay, 1'b0, FAULT_NONE);
        foreach (pay[k]) pay[k] = 32'hFFFF_FFFF;
        send_frame(pay, 1'b1, FAULT_NONE);
        foreach (pay[k]) pay[k] = k[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
        send_frame(pay, 1'b1, FAULT_NONE);
        for (f = FAULT_SYNC; f <= FAULT_CK_B; f = frame_fault_t'(f + 1))
            send_frame(pay, 1'b1, f);
        send_frame(pay, 1'b0, FAULT_CLASS);
        // drop an unfinished frame by restarting, then feed bytes to an idle parser
        send_frame(pay, 1'b1, FAULT_CUT);
        send_frame(pay, 1'b0, FAULT_NONE);
        send_byte(SyncFirst, 1'b0);
        send_byte(FrameClass, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(SyncFirst, 1'b1);
        send_frame(pay, 1'b1, FAULT_NONE);
        drain_results();

        while (items_taken < 1400) begin
            if (frames == 12) hold_request = 1'b1;
            if (frames % 20 == 10) drain_results();
            no_idle = ($urandom_range(0, 3) == 0);
            random_payload(pay);
            r = $urandom_range(0, 99);
            if (r < 62) begin
                send_frame(pay, 1'($urandom_range(0, 1)), FAULT_NONE);
            end else if (r < 70) begin
                send_frame(pay, 1'($urandom_range(0, 1)),
                           $urandom_range(0, 1) ? FAULT_CK_A : FAULT_CK_B);
            end else if (r < 82) begin
                f = frame_fault_t'($urandom_range(FAULT_SYNC, FAULT_LEN_HI));
                send_frame(pay, (f == FAULT_SYNC) || $urandom_range(0, 1), f);
            end else if (r < 90) begin
                send_frame(pay, 1'($urandom_range(0, 1)), FAULT_CUT);
            end else if (r < 96) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            frames++;
        end

        no_idle = 1'b0;
        drain_results();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
